### rtl/tgpr_pkg.sv
// Shared types, command codes and defaults for the text glyph pixel renderer.
package tgpr_pkg;

	localparam int GlyphWidthDef = 6;
	localparam int GlyphHeightDef = 8;
	localparam int DisplayWidthDef = 96;
	localparam int DisplayHeightDef = 64;

	// Codes with the top bit set are never drawn or loaded, so the store holds 128 glyphs.
	localparam int CodeCount = 128;
	localparam int IgnoreBit = 7;

	localparam int CmdDepth = 4;
	localparam int PixDepth = 4;

	localparam int ColorW = 16;
	localparam int CfgIdxW = 1;

	localparam logic [1:0] CMD_PUT = 2'd0;
	localparam logic [1:0] CMD_CURSOR = 2'd1;
	localparam logic [1:0] CMD_LOAD = 2'd2;

	localparam logic [CfgIdxW-1:0] REG_TEXT_COLOR = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_BACKGROUND_COLOR = 1'd1;

	localparam logic [ColorW-1:0] TextColorReset = 16'd2016;
	localparam logic [ColorW-1:0] BackgroundColorReset = 16'd0;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] char_code;
		logic [7:0] cursor_col_in;
		logic [7:0] cursor_row_in;
		logic [2:0] glyph_column;
		logic [7:0] glyph_bits;
	} in_item_t;

	typedef struct packed {
		logic [15:0] pixel_color;
		logic [6:0]  pixel_x;
		logic [5:0]  pixel_y;
		logic        last;
	} out_item_t;

	// Work handed from the front to the back: either a glyph byte load or a draw.
	typedef struct packed {
		logic       is_load;
		logic [6:0] code;
		logic [2:0] glyph_column;
		logic [7:0] glyph_bits;
		logic [7:0] x0;
		logic [7:0] y0;
	} job_t;

	typedef struct packed {
		logic busy;
		logic issue_last;
	} back_status_t;

	typedef enum logic {
		ST_IDLE,
		ST_DRAW
	} seq_state_t;

endpackage

### rtl/tgpr_queue.sv
// Small register-based FIFO used between the front, the back and the result port.
module tgpr_queue #(
	parameter int WIDTH = $bits(tgpr_pkg::job_t),
	parameter int DEPTH = tgpr_pkg::CmdDepth
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	output logic                       full,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PtrW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entries_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full = (count_q == CntW'(DEPTH));
	assign empty = (count_q == '0);
	assign count = count_q;
	assign rdata = entries_q[rd_ptr_q];
	assign do_push = push & ~full;
	assign do_pop = pop & ~empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

### rtl/tgpr_front.sv
// Front end: accepts items, keeps the character cursor and queues loads and draws.
module tgpr_front #(
	parameter int GLYPH_WIDTH = tgpr_pkg::GlyphWidthDef,
	parameter int GLYPH_HEIGHT = tgpr_pkg::GlyphHeightDef,
	parameter int DISPLAY_WIDTH = tgpr_pkg::DisplayWidthDef,
	parameter int DISPLAY_HEIGHT = tgpr_pkg::DisplayHeightDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  tgpr_pkg::in_item_t item,
	input  logic               cmd_full,
	output logic               cmd_push,
	output tgpr_pkg::job_t     job
);

	localparam int Cols = DISPLAY_WIDTH / GLYPH_WIDTH;
	localparam int Rows = DISPLAY_HEIGHT / GLYPH_HEIGHT;
	localparam int ColW = (Cols > 1) ? $clog2(Cols) : 1;
	localparam int RowW = (Rows > 1) ? $clog2(Rows) : 1;

	logic [ColW-1:0] cursor_col_q;
	logic [RowW-1:0] cursor_row_q;
	logic            accept;
	logic            ignored;
	logic            is_put;
	logic            is_cursor;
	logic            is_load;
	logic            load_ok;
	logic [ColW:0]   col_inc;
	logic [RowW:0]   row_inc;
	logic [ColW-1:0] col_clamped;
	logic [RowW-1:0] row_clamped;

	assign full = cmd_full;
	assign accept = push & ~cmd_full;
	assign ignored = item.char_code[tgpr_pkg::IgnoreBit];
	assign is_put = (item.cmd == tgpr_pkg::CMD_PUT);
	assign is_cursor = (item.cmd == tgpr_pkg::CMD_CURSOR);
	assign is_load = (item.cmd == tgpr_pkg::CMD_LOAD);
	assign load_ok = ~ignored & ({1'b0, item.glyph_column} < 4'(GLYPH_WIDTH));

	// Only visible characters and in-range loads need the back end.
	assign cmd_push = accept & ((is_put & ~ignored) | (is_load & load_ok));

	always_comb begin
		job.is_load = is_load;
		job.code = item.char_code[6:0];
		job.glyph_column = item.glyph_column;
		job.glyph_bits = item.glyph_bits;
		job.x0 = 8'(cursor_col_q * GLYPH_WIDTH);
		job.y0 = 8'(cursor_row_q * GLYPH_HEIGHT);
	end

	assign col_inc = {1'b0, cursor_col_q} + (ColW + 1)'(1);
	assign row_inc = {1'b0, cursor_row_q} + (RowW + 1)'(1);

	always_comb begin
		if ({1'b0, item.cursor_col_in} >= 9'(Cols)) begin
			col_clamped = ColW'(Cols - 1);
		end else begin
			col_clamped = ColW'(item.cursor_col_in);
		end
		if ({1'b0, item.cursor_row_in} >= 9'(Rows)) begin
			row_clamped = RowW'(Rows - 1);
		end else begin
			row_clamped = RowW'(item.cursor_row_in);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q <= '0;
			cursor_row_q <= '0;
		end else if (accept) begin
			if (is_put) begin
				// The cursor moves on even for an ignored character.
				if (col_inc >= (ColW + 1)'(Cols)) begin
					cursor_col_q <= '0;
					cursor_row_q <= (row_inc >= (RowW + 1)'(Rows)) ? '0 : row_inc[RowW-1:0];
				end else begin
					cursor_col_q <= col_inc[ColW-1:0];
				end
			end else if (is_cursor) begin
				cursor_col_q <= col_clamped;
				cursor_row_q <= row_clamped;
			end
		end
	end

endmodule

### rtl/tgpr_back.sv
// Back end: glyph store and the sequencer that expands a character into pixels.
module tgpr_back #(
	parameter int GLYPH_WIDTH = tgpr_pkg::GlyphWidthDef,
	parameter int GLYPH_HEIGHT = tgpr_pkg::GlyphHeightDef
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cmd_empty,
	input  tgpr_pkg::job_t                            job,
	output logic                                      cmd_pop,
	input  logic [tgpr_pkg::ColorW-1:0]               text_color,
	input  logic [tgpr_pkg::ColorW-1:0]               background_color,
	input  logic [$clog2(tgpr_pkg::PixDepth+1)-1:0]   pix_count,
	output logic                                      pix_push,
	output tgpr_pkg::out_item_t                       pixel,
	output tgpr_pkg::back_status_t                    status
);

	localparam int StoreDepth = tgpr_pkg::CodeCount * GLYPH_WIDTH;
	localparam int AddrW = $clog2(StoreDepth);
	localparam int CntW = $clog2(tgpr_pkg::PixDepth + 1);

	logic [7:0] store_mem [StoreDepth];

	tgpr_pkg::seq_state_t state_q;
	tgpr_pkg::seq_state_t state_next;

	logic [AddrW-1:0] base_q;
	logic [7:0]       x0_q;
	logic [7:0]       y0_q;
	logic [2:0]       col_q;
	logic [2:0]       row_q;

	logic             valid_s1;
	logic [7:0]       x_s1;
	logic [7:0]       y_s1;
	logic [2:0]       row_s1;
	logic             last_s1;
	logic [7:0]       glyph_byte_s1;

	logic             mem_we;
	logic             issue;
	logic             space;
	logic             col_end;
	logic             row_end;
	logic             issue_last;
	logic [AddrW-1:0] load_addr;
	logic [AddrW-1:0] rd_addr;

	assign load_addr = AddrW'(job.code * GLYPH_WIDTH) + AddrW'(job.glyph_column);
	assign rd_addr = base_q + AddrW'(col_q);

	// A read in flight still needs a slot, so it counts against the pixel queue.
	assign space = ((CntW + 1)'(pix_count) + (CntW + 1)'(valid_s1))
		< (CntW + 1)'(tgpr_pkg::PixDepth);

	assign col_end = (col_q == 3'(GLYPH_WIDTH - 1));
	assign row_end = (row_q == 3'(GLYPH_HEIGHT - 1));
	assign issue_last = issue & col_end & row_end;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			tgpr_pkg::ST_IDLE: begin
				if (!cmd_empty && !job.is_load) begin
					state_next = tgpr_pkg::ST_DRAW;
				end
			end
			tgpr_pkg::ST_DRAW: begin
				if (issue_last) begin
					state_next = tgpr_pkg::ST_IDLE;
				end
			end
			default: state_next = tgpr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop = 1'b0;
		issue = 1'b0;
		unique case (state_q)
			tgpr_pkg::ST_IDLE: cmd_pop = ~cmd_empty;
			tgpr_pkg::ST_DRAW: issue = space;
			default: begin
				cmd_pop = 1'b0;
				issue = 1'b0;
			end
		endcase
	end

	assign mem_we = cmd_pop & job.is_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tgpr_pkg::ST_IDLE;
			col_q <= '0;
			row_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q <= state_next;
			valid_s1 <= issue;
			if (cmd_pop && !job.is_load) begin
				col_q <= '0;
				row_q <= '0;
			end else if (issue) begin
				if (col_end) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && !job.is_load) begin
			base_q <= AddrW'(job.code * GLYPH_WIDTH);
			x0_q <= job.x0;
			y0_q <= job.y0;
		end
		if (issue) begin
			x_s1 <= x0_q + 8'(col_q);
			y_s1 <= y0_q + 8'(row_q);
			row_s1 <= row_q;
			last_s1 <= col_end & row_end;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[load_addr] <= job.glyph_bits;
		end
		if (issue) begin
			glyph_byte_s1 <= store_mem[rd_addr];
		end
	end

	assign pix_push = valid_s1;

	always_comb begin
		pixel.pixel_color = glyph_byte_s1[row_s1] ? text_color : background_color;
		pixel.pixel_x = 7'(x_s1);
		pixel.pixel_y = 6'(y_s1);
		pixel.last = last_s1;
	end

	always_comb begin
		status.busy = (state_q == tgpr_pkg::ST_DRAW);
		status.issue_last = issue_last;
	end

endmodule

### rtl/text_glyph_pixel_renderer.sv
// Top level of the text-mode character generator: front, job queue, back, pixel queue.
// The first pixel of a character passes the job queue, the back end's draw state and the
// glyph store read register into the pixel queue. A drawn character gives GLYPH_WIDTH *
// GLYPH_HEIGHT pixels (48 by default), one pixel per cycle while the pixel queue has room,
// set by the single glyph store read port. Loads only write the glyph store; cursor moves
// and ignored codes never reach the back end. Reset clears the cursor and the queues and
// restores the default colors; the glyph store is not cleared.
module text_glyph_pixel_renderer #(
	parameter int GLYPH_WIDTH = tgpr_pkg::GlyphWidthDef,
	parameter int GLYPH_HEIGHT = tgpr_pkg::GlyphHeightDef,
	parameter int DISPLAY_WIDTH = tgpr_pkg::DisplayWidthDef,
	parameter int DISPLAY_HEIGHT = tgpr_pkg::DisplayHeightDef
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  tgpr_pkg::in_item_t               item,
	output logic                             empty,
	input  logic                             pop,
	output tgpr_pkg::out_item_t              pixel,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tgpr_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [tgpr_pkg::ColorW-1:0]      cfg_data
);

	localparam int JobW = $bits(tgpr_pkg::job_t);
	localparam int PixW = $bits(tgpr_pkg::out_item_t);
	localparam int CmdCntW = $clog2(tgpr_pkg::CmdDepth + 1);
	localparam int PixCntW = $clog2(tgpr_pkg::PixDepth + 1);

	logic [tgpr_pkg::ColorW-1:0] text_color_q;
	logic [tgpr_pkg::ColorW-1:0] background_color_q;

	tgpr_pkg::job_t         front_job;
	tgpr_pkg::job_t         head_job;
	tgpr_pkg::out_item_t    back_pixel;
	tgpr_pkg::back_status_t back_status;

	logic               cmd_push;
	logic               cmd_pop;
	logic               cmd_full;
	logic               cmd_empty;
	logic [CmdCntW-1:0] cmd_count;
	logic [JobW-1:0]    cmd_rdata;
	logic               pix_push;
	logic               pix_full;
	logic [PixCntW-1:0] pix_count;
	logic [PixW-1:0]    pix_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= tgpr_pkg::TextColorReset;
			background_color_q <= tgpr_pkg::BackgroundColorReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tgpr_pkg::REG_TEXT_COLOR: text_color_q <= cfg_data;
				tgpr_pkg::REG_BACKGROUND_COLOR: background_color_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tgpr_front #(
		.GLYPH_WIDTH(GLYPH_WIDTH),
		.GLYPH_HEIGHT(GLYPH_HEIGHT),
		.DISPLAY_WIDTH(DISPLAY_WIDTH),
		.DISPLAY_HEIGHT(DISPLAY_HEIGHT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.cmd_full(cmd_full),
		.cmd_push(cmd_push),
		.job(front_job)
	);

	tgpr_queue #(
		.WIDTH(JobW),
		.DEPTH(tgpr_pkg::CmdDepth)
	) u_cmd_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(cmd_push),
		.wdata(front_job),
		.full(cmd_full),
		.pop(cmd_pop),
		.rdata(cmd_rdata),
		.empty(cmd_empty),
		.count(cmd_count)
	);

	assign head_job = tgpr_pkg::job_t'(cmd_rdata);

	tgpr_back #(
		.GLYPH_WIDTH(GLYPH_WIDTH),
		.GLYPH_HEIGHT(GLYPH_HEIGHT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_empty(cmd_empty),
		.job(head_job),
		.cmd_pop(cmd_pop),
		.text_color(text_color_q),
		.background_color(background_color_q),
		.pix_count(pix_count),
		.pix_push(pix_push),
		.pixel(back_pixel),
		.status(back_status)
	);

	tgpr_queue #(
		.WIDTH(PixW),
		.DEPTH(tgpr_pkg::PixDepth)
	) u_pix_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(pix_push),
		.wdata(back_pixel),
		.full(pix_full),
		.pop(pop),
		.rdata(pix_rdata),
		.empty(empty),
		.count(pix_count)
	);

	assign pixel = tgpr_pkg::out_item_t'(pix_rdata);

	// The back end reserves a pixel slot before it reads the store.
	a_pix_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		pix_push |-> !pix_full)
		else $error("pixel queue written while full");

	a_job_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("job taken from an empty queue");

	a_draw_ends_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(back_status.busy) |-> $past(back_status.issue_last))
		else $error("draw ended before the last pixel was issued");

	a_job_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_count <= CmdCntW'(tgpr_pkg::CmdDepth))
		else $error("job queue count out of range");

endmodule

### bench/text_glyph_pixel_renderer_test.sv
// Self-checking bench for the text glyph pixel renderer: a directed table, then random traffic.
module text_glyph_pixel_renderer_test;

	localparam int GlyphW = tgpr_pkg::GlyphWidthDef;
	localparam int GlyphH = tgpr_pkg::GlyphHeightDef;
	localparam int CharCols = tgpr_pkg::DisplayWidthDef / tgpr_pkg::GlyphWidthDef;
	localparam int CharRows = tgpr_pkg::DisplayHeightDef / tgpr_pkg::GlyphHeightDef;
	localparam int ColBits = $clog2(CharCols);
	localparam int RowBits = $clog2(CharRows);
	localparam int IdlePct = 33;
	localparam int PhaseItems = 40;
	localparam int SettleCycles = 16;
	localparam int CycleLimit = 250000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		tgpr_pkg::in_item_t  stim;
		bit                  typed;
		tgpr_pkg::out_item_t head_px;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	tgpr_pkg::in_item_t item = '0;
	logic empty;
	logic pop = 1'b0;
	tgpr_pkg::out_item_t pixel;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [tgpr_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [tgpr_pkg::ColorW-1:0] cfg_data = '0;

	logic [tgpr_pkg::ColorW-1:0] text_rgb = tgpr_pkg::TextColorReset;
	logic [tgpr_pkg::ColorW-1:0] back_rgb = tgpr_pkg::BackgroundColorReset;
	logic [ColBits-1:0] cur_col = '0;
	logic [RowBits-1:0] cur_row = '0;
	logic [7:0] glyph_mem [GlyphW*tgpr_pkg::CodeCount];
	bit [GlyphW-1:0] cols_loaded [tgpr_pkg::CodeCount];
	logic [6:0] drawable_codes [$];
	tgpr_pkg::out_item_t pixel_queue [$];
	step_t steps [$];
	bit steady = 1'b0;
	int mismatches = 0;
	int cycles = 0;

	text_glyph_pixel_renderer dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.pixel(pixel),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic tgpr_pkg::in_item_t noise_item();
		tgpr_pkg::in_item_t x;
		x.cmd = 2'($urandom);
		x.char_code = 8'($urandom);
		x.cursor_col_in = 8'($urandom);
		x.cursor_row_in = 8'($urandom);
		x.glyph_column = 3'($urandom);
		x.glyph_bits = 8'($urandom);
		return x;
	endfunction

	function automatic step_t load_step(input logic [7:0] code, input logic [2:0] column,
			input logic [7:0] bits);
		step_t s;
		s.stim = noise_item();
		s.stim.cmd = tgpr_pkg::CMD_LOAD;
		s.stim.char_code = code;
		s.stim.glyph_column = column;
		s.stim.glyph_bits = bits;
		s.typed = 1'b0;
		s.head_px = '0;
		return s;
	endfunction

	function automatic step_t put_step(input logic [7:0] code);
		step_t s;
		s.stim = noise_item();
		s.stim.cmd = tgpr_pkg::CMD_PUT;
		s.stim.char_code = code;
		s.typed = 1'b0;
		s.head_px = '0;
		return s;
	endfunction

	// The first pixel of the character is given by hand instead of by the predictor.
	function automatic step_t typed_put(input logic [7:0] code,
			input logic [tgpr_pkg::ColorW-1:0] color, input int px, input int py);
		step_t s;
		s = put_step(code);
		s.typed = 1'b1;
		s.head_px.pixel_color = color;
		s.head_px.pixel_x = 7'(px);
		s.head_px.pixel_y = 6'(py);
		s.head_px.last = 1'b0;
		return s;
	endfunction

	function automatic step_t cursor_step(input logic [7:0] col, input logic [7:0] row);
		step_t s;
		s.stim = noise_item();
		s.stim.cmd = tgpr_pkg::CMD_CURSOR;
		s.stim.cursor_col_in = col;
		s.stim.cursor_row_in = row;
		s.typed = 1'b0;
		s.head_px = '0;
		return s;
	endfunction

	function automatic void predict_pixels(input tgpr_pkg::in_item_t x, input bit typed,
			input tgpr_pkg::out_item_t head_px);
		tgpr_pkg::out_item_t px;
		logic [7:0] colbyte;
		logic [6:0] code;
		int n0, r, c;
		code = x.char_code[6:0];
		case (x.cmd)
			tgpr_pkg::CMD_PUT: begin
				if (!x.char_code[tgpr_pkg::IgnoreBit]) begin
					n0 = pixel_queue.size();
					for (r = 0; r < GlyphH; r++) begin
						for (c = 0; c < GlyphW; c++) begin
							colbyte = glyph_mem[int'(code) * GlyphW + c];
							px.pixel_color = colbyte[r] ? text_rgb : back_rgb;
							px.pixel_x = 7'(int'(cur_col) * GlyphW + c);
							px.pixel_y = 6'(int'(cur_row) * GlyphH + r);
							px.last = (r == GlyphH - 1) && (c == GlyphW - 1);
							pixel_queue.push_back(px);
						end
					end
					if (typed)
						pixel_queue[n0] = head_px;
				end
				// Ignored codes still move the cursor.
				if (int'(cur_col) == CharCols - 1) begin
					cur_col = '0;
					cur_row = (int'(cur_row) == CharRows - 1) ? '0 : cur_row + 1'b1;
				end else begin
					cur_col = cur_col + 1'b1;
				end
			end
			tgpr_pkg::CMD_CURSOR: begin
				cur_col = (int'(x.cursor_col_in) >= CharCols) ?
					ColBits'(CharCols - 1) : x.cursor_col_in[ColBits-1:0];
				cur_row = (int'(x.cursor_row_in) >= CharRows) ?
					RowBits'(CharRows - 1) : x.cursor_row_in[RowBits-1:0];
			end
			tgpr_pkg::CMD_LOAD: begin
				if (!x.char_code[tgpr_pkg::IgnoreBit] && int'(x.glyph_column) < GlyphW) begin
					glyph_mem[int'(code) * GlyphW + int'(x.glyph_column)] = x.glyph_bits;
					if (!(&cols_loaded[code])) begin
						cols_loaded[code][x.glyph_column] = 1'b1;
						if (&cols_loaded[code])
							drawable_codes.push_back(code);
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void check_pixel(input tgpr_pkg::out_item_t got);
		tgpr_pkg::out_item_t want;
		if (pixel_queue.size() == 0) begin
			$error("pixel with none expected: color %h x %0d y %0d last %0b",
				got.pixel_color, got.pixel_x, got.pixel_y, got.last);
			mismatches++;
		end else begin
			want = pixel_queue.pop_front();
			if (got.pixel_color !== want.pixel_color) begin
				$error("pixel_color: expected %h, got %h", want.pixel_color, got.pixel_color);
				mismatches++;
			end
			if (got.pixel_x !== want.pixel_x) begin
				$error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
				mismatches++;
			end
			if (got.pixel_y !== want.pixel_y) begin
				$error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, got.last);
				mismatches++;
			end
		end
	endfunction

	// Push stays high from one transfer to the next unless a gap is chosen.
	task automatic send_item(input tgpr_pkg::in_item_t x, input bit typed,
			input tgpr_pkg::out_item_t head_px);
		if (!steady && $urandom_range(99) < IdlePct) begin
			push <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IdlePct);
		end
		push <= 1'b1;
		item <= x;
		do @(posedge clk); while (full);
		predict_pixels(x, typed, head_px);
	endtask

	task automatic settle();
		push <= 1'b0;
		while (pixel_queue.size() != 0)
			@(posedge clk);
		// Loads queued behind the last character may still be in flight.
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic set_colors(input logic [tgpr_pkg::ColorW-1:0] fg,
			input logic [tgpr_pkg::ColorW-1:0] bg);
		cfg_valid <= 1'b1;
		cfg_index <= tgpr_pkg::REG_TEXT_COLOR;
		cfg_data <= fg;
		do @(posedge clk); while (!cfg_ready);
		text_rgb = fg;
		cfg_index <= tgpr_pkg::REG_BACKGROUND_COLOR;
		cfg_data <= bg;
		do @(posedge clk); while (!cfg_ready);
		back_rgb = bg;
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input int quota);
		tgpr_pkg::in_item_t x;
		logic [6:0] code;
		int counted, r, c;
		counted = 0;
		while (counted < quota) begin
			r = $urandom_range(99);
			if (r < 15 || drawable_codes.size() == 0) begin
				// Define a whole glyph so that later characters can draw it.
				code = 7'($urandom_range(tgpr_pkg::CodeCount - 1));
				for (c = 0; c < GlyphW; c++) begin
					x = noise_item();
					x.cmd = tgpr_pkg::CMD_LOAD;
					x.char_code = {1'b0, code};
					x.glyph_column = 3'(c);
					send_item(x, 1'b0, '0);
				end
				counted += GlyphW;
			end else begin
				x = noise_item();
				if (r < 55) begin
					x.cmd = tgpr_pkg::CMD_PUT;
					x.char_code = {1'b0,
						drawable_codes[$urandom_range(drawable_codes.size() - 1)]};
					counted++;
				end else if (r < 65) begin
					x.cmd = tgpr_pkg::CMD_CURSOR;
					if ($urandom_range(1) == 1) begin
						x.cursor_col_in = 8'($urandom_range(CharCols - 1));
						x.cursor_row_in = 8'($urandom_range(CharRows - 1));
					end
					counted++;
				end else if (r < 73) begin
					x.cmd = tgpr_pkg::CMD_LOAD;
					x.char_code = 8'($urandom_range(tgpr_pkg::CodeCount - 1));
					x.glyph_column = 3'($urandom_range(GlyphW - 1));
					counted++;
				end else if (r < 81) begin
					x.cmd = tgpr_pkg::CMD_PUT;
					x.char_code = 8'($urandom_range(255, 128));
					counted++;
				end else if (r < 88) begin
					x.cmd = CMD_UNUSED;
				end else begin
					x.cmd = tgpr_pkg::CMD_LOAD;
					if ($urandom_range(1) == 1) begin
						x.char_code[tgpr_pkg::IgnoreBit] = 1'b1;
					end else begin
						x.char_code[tgpr_pkg::IgnoreBit] = 1'b0;
						x.glyph_column = 3'($urandom_range(7, GlyphW));
					end
				end
				send_item(x, 1'b0, '0);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				check_pixel(pixel);
			pop <= steady || ($urandom_range(99) >= IdlePct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("[text_glyph_pixel_renderer] ERROR");
			$finish;
		end
	end

	initial begin
		int ph;
		step_t s;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		steps.push_back(load_step(8'd0, 3'd0, 8'hFF));
		steps.push_back(load_step(8'd0, 3'd1, 8'h00));
		steps.push_back(load_step(8'd0, 3'd2, 8'hAA));
		steps.push_back(load_step(8'd0, 3'd3, 8'h55));
		steps.push_back(load_step(8'd0, 3'd4, 8'h01));
		steps.push_back(load_step(8'd0, 3'd5, 8'h80));
		steps.push_back(load_step(8'd127, 3'd0, 8'h00));
		steps.push_back(load_step(8'd127, 3'd1, 8'hFF));
		steps.push_back(load_step(8'd127, 3'd2, 8'h0F));
		steps.push_back(load_step(8'd127, 3'd3, 8'hF0));
		steps.push_back(load_step(8'd127, 3'd4, 8'h81));
		steps.push_back(load_step(8'd127, 3'd5, 8'h7E));
		steps.push_back(typed_put(8'd0, tgpr_pkg::TextColorReset, 0, 0));
		steps.push_back(cursor_step(8'd255, 8'd255));
		// Bottom right cell; the cursor wraps back to the origin afterwards.
		steps.push_back(typed_put(8'd127, tgpr_pkg::BackgroundColorReset, 90, 56));
		steps.push_back(put_step(8'h80));
		steps.push_back(put_step(8'hFF));
		s.stim = noise_item();
		s.stim.cmd = CMD_UNUSED;
		s.typed = 1'b0;
		s.head_px = '0;
		steps.push_back(s);
		steps.push_back(load_step(8'h85, 3'd0, 8'h3C));
		steps.push_back(load_step(8'd3, 3'd6, 8'hC3));
		steps.push_back(load_step(8'd3, 3'd7, 8'h5A));
		steps.push_back(cursor_step(8'd16, 8'd8));
		steps.push_back(typed_put(8'd0, tgpr_pkg::TextColorReset, 90, 56));
		steps.push_back(cursor_step(8'd15, 8'd0));
		steps.push_back(typed_put(8'd127, tgpr_pkg::BackgroundColorReset, 90, 0));
		steps.push_back(typed_put(8'd0, tgpr_pkg::TextColorReset, 0, 8));

		foreach (steps[i])
			send_item(steps[i].stim, steps[i].typed, steps[i].head_px);
		settle();

		for (ph = 1; ph <= 5; ph++) begin
			case (ph)
				1: set_colors(16'hFFFF, 16'h0000);
				2: set_colors(16'h0000, 16'hFFFF);
				default: set_colors(16'($urandom), 16'($urandom));
			endcase
			steady <= (ph == 3);
			random_phase(PhaseItems);
			settle();
		end

		if (mismatches == 0)
			$display("[text_glyph_pixel_renderer] OK");
		else
			$display("[text_glyph_pixel_renderer] ERROR");
		$finish;
	end

endmodule

### text_glyph_pixel_renderer.f
rtl/tgpr_pkg.sv
rtl/tgpr_queue.sv
rtl/tgpr_front.sv
rtl/tgpr_back.sv
rtl/text_glyph_pixel_renderer.sv
bench/text_glyph_pixel_renderer_test.sv
